[hw/rtl/ccq_pkg.sv]
package ccq_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

	// Characters that the scanner reacts to.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Verdict codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_MISSING  = 3'd1;
	localparam logic [2:0] ST_UNEXPECT = 3'd2;
	localparam logic [2:0] ST_COMMENT  = 3'd3;
	localparam logic [2:0] ST_QUOTE    = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
		logic push_bit; // 1 expects ')', 0 expects '}'
	} stack_ctl_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               top;
	} stack_stat_t;

endpackage

[hw/rtl/ccq_stack.sv]
module ccq_stack
	import ccq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  stack_ctl_t  ctl,
	output stack_stat_t stat
);

	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] depth_n;
	logic               top_q;
	logic               below_q;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic               mem [STACK_DEPTH];

	// The top entry lives in top_q; the memory holds the entries beneath it.
	// below_q always holds the entry just under the top, prefetched for a pop.
	always_comb begin
		priority if (ctl.clear) begin
			depth_n = '0;
		end else if (ctl.push) begin
			depth_n = depth_q + 1'b1;
		end else if (ctl.pop) begin
			depth_n = depth_q - 1'b1;
		end else begin
			depth_n = depth_q;
		end
	end

	assign wr_addr = ADDR_W'(depth_q - 1'b1);
	assign rd_addr = ADDR_W'(depth_n - DEPTH_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			depth_q <= depth_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && depth_q != '0) begin
			mem[wr_addr] <= top_q;
		end
		// After a push the entry under the new top is the old top.
		if (ctl.push) begin
			below_q <= top_q;
		end else begin
			below_q <= mem[rd_addr];
		end
		if (ctl.push) begin
			top_q <= ctl.push_bit;
		end else if (ctl.pop) begin
			top_q <= below_q;
		end
	end

	assign stat.depth = depth_q;
	assign stat.top   = top_q;

endmodule

[hw/rtl/c_bracket_quote_checker.sv]
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] ch
// m_axis    out        tdata[2:0] status, tdata[10:3] detail_char
// cfg       in         cfg_data[7:0] top_closer
//
// One byte is taken every cycle unless the output stalls; a verdict appears in the cycle after its byte.
// The scan state and the top of the closer stack update in that same cycle;
// the stack memory prefetches the entry under the top for the next pop.
// Reset returns to normal scanning at depth 0 with top_closer 0.
// Input stalls only while a verdict waits in the output register.
module c_bracket_quote_checker
	import ccq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [2:0] status, [10:3] detail_char, [15:11] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data       // [7:0] top_closer
);

	localparam logic [2:0] M_NORMAL = 3'd0;
	localparam logic [2:0] M_SLASH  = 3'd1;
	localparam logic [2:0] M_LINE   = 3'd2;
	localparam logic [2:0] M_BLOCK  = 3'd3;
	localparam logic [2:0] M_BSTAR  = 3'd4;
	localparam logic [2:0] M_QUOTE  = 3'd5;
	localparam logic [2:0] M_ESCAPE = 3'd6;
	localparam logic [2:0] M_ABSORB = 3'd7;

	logic [2:0]  mode_q, mode_n;
	logic        qsingle_q, qsingle_n;
	logic [7:0]  top_closer_q;
	logic        m_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  detail_q;

	stack_ctl_t  sctl;
	stack_stat_t sstat;

	logic        s_fire;
	logic [7:0]  c;
	logic [7:0]  qch;
	logic [7:0]  expect_ch;
	logic        do_normal;
	logic        do_push;
	logic        push_bit;
	logic        pop;
	logic        clear;
	logic        emit;
	logic        at_end;
	logic [2:0]  st;
	logic [7:0]  det;

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign c             = s_axis_tdata;
	assign qch           = qsingle_q ? CH_SQUOTE : CH_DQUOTE;
	assign expect_ch     = (sstat.depth == '0) ? top_closer_q :
	                       (sstat.top ? CH_RPAR : CH_RBRACE);

	always_comb begin
		mode_n    = mode_q;
		qsingle_n = qsingle_q;
		do_normal = 1'b0;
		do_push   = 1'b0;
		push_bit  = 1'b0;
		pop       = 1'b0;
		clear     = 1'b0;
		emit      = 1'b0;
		at_end    = 1'b0;
		st        = ST_OK;
		det       = 8'h00;

		unique case (mode_q)
			M_SLASH: begin
				if (c == CH_SLASH) begin
					mode_n = M_LINE;
				end else if (c == CH_STAR) begin
					mode_n = M_BLOCK;
				end else begin
					do_normal = 1'b1;
				end
			end
			M_LINE: begin
				if (c == CH_NUL || c == CH_NL) begin
					do_normal = 1'b1;
				end
			end
			M_BLOCK, M_BSTAR: begin
				if (c == CH_NUL) begin
					emit   = 1'b1;
					at_end = 1'b1;
					st     = ST_COMMENT;
				end else if (mode_q == M_BSTAR && c == CH_SLASH) begin
					mode_n = M_NORMAL;
				end else begin
					mode_n = (c == CH_STAR) ? M_BSTAR : M_BLOCK;
				end
			end
			M_QUOTE, M_ESCAPE: begin
				if (c == CH_NUL) begin
					emit   = 1'b1;
					at_end = 1'b1;
					st     = ST_QUOTE;
					det    = qch;
				end else if (mode_q == M_ESCAPE) begin
					mode_n = M_QUOTE;
				end else if (c == CH_BSLASH) begin
					mode_n = M_ESCAPE;
				end else if (c == qch) begin
					mode_n = M_NORMAL;
				end
			end
			M_ABSORB: begin
				if (c == CH_NUL) begin
					mode_n    = M_NORMAL;
					qsingle_n = 1'b0;
					clear     = 1'b1;
				end
			end
			default: begin
				do_normal = 1'b1;
			end
		endcase

		if (do_normal) begin
			mode_n = M_NORMAL;
			unique case (c)
				CH_NUL: begin
					emit   = 1'b1;
					at_end = 1'b1;
					st     = (expect_ch == CH_NUL) ? ST_OK : ST_MISSING;
					det    = expect_ch;
				end
				CH_SLASH: mode_n = M_SLASH;
				CH_HASH:  mode_n = M_LINE;
				CH_LBRACE: begin
					if (expect_ch == CH_RPAR) begin
						emit = 1'b1;
						st   = ST_UNEXPECT;
						det  = c;
					end else begin
						do_push = 1'b1;
					end
				end
				CH_LPAR: begin
					do_push  = 1'b1;
					push_bit = 1'b1;
				end
				CH_DQUOTE: begin
					qsingle_n = 1'b0;
					mode_n    = M_QUOTE;
				end
				CH_SQUOTE: begin
					qsingle_n = 1'b1;
					mode_n    = M_QUOTE;
				end
				CH_RBRACE, CH_RPAR: begin
					if (expect_ch != c) begin
						emit = 1'b1;
						st   = ST_UNEXPECT;
						det  = c;
					end else if (sstat.depth == '0) begin
						emit = 1'b1;
					end else begin
						pop = 1'b1;
					end
				end
				default: ;
			endcase
		end

		// A full stack turns the opener into an overflow verdict.
		if (do_push && sstat.depth >= DEPTH_FULL) begin
			do_push = 1'b0;
			emit    = 1'b1;
			st      = ST_OVERFLOW;
		end

		if (emit) begin
			if (at_end) begin
				mode_n    = M_NORMAL;
				qsingle_n = 1'b0;
				clear     = 1'b1;
			end else begin
				mode_n = M_ABSORB;
			end
		end
	end

	assign sctl.push     = s_fire && do_push;
	assign sctl.pop      = s_fire && pop;
	assign sctl.clear    = s_fire && clear;
	assign sctl.push_bit = push_bit;

	ccq_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.stat   (sstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_NORMAL;
			qsingle_q    <= 1'b0;
			top_closer_q <= 8'h00;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				top_closer_q <= cfg_data;
			end
			if (s_fire) begin
				mode_q    <= mode_n;
				qsingle_q <= qsingle_n;
			end
			if (s_axis_tready) begin
				m_valid_q <= s_fire && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && emit) begin
			status_q <= st;
			detail_q <= det;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, detail_q, status_q};

	// Verdict codes stay within the defined set.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> status_q <= ST_OVERFLOW)
		else $error("verdict code out of range");

	// Verdicts without a character carry a zero detail.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (status_q == ST_OK || status_q == ST_COMMENT ||
		status_q == ST_OVERFLOW) |-> detail_q == 8'h00)
		else $error("nonzero detail on a verdict without a character");

	// The nesting depth never passes the stack size.
	assert property (@(posedge clk) disable iff (!arst_n)
		sstat.depth <= DEPTH_FULL)
		else $error("nesting depth beyond stack size");

	// A terminating NUL always rearms the scanner.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && c == CH_NUL |=> mode_q == M_NORMAL && sstat.depth == '0 && !qsingle_q)
		else $error("scanner not rearmed after end of string");

	// While absorbing, no further verdict is produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && mode_q == M_ABSORB |=> !m_valid_q || $stable(status_q) && $stable(detail_q))
		else $error("verdict produced while absorbing");

endmodule
